// ----- rtl/assert_macros.svh -----
// assertion macros for the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define RCMR_ASSERT_IMPL(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock, off during reset
`define RCMR_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ----- rtl/rcmr_pkg.sv -----
// shared types, constants and gain table function for the mute ramp block
`timescale 1ns / 1ps

package rcmr_pkg;

   localparam int RISE_RAMP_LEN_DEF = 512;
   localparam int FALL_RAMP_LEN_DEF = 512;
   localparam int SAMPLE_BITS_DEF   = 24;

   localparam int OPCODE_W   = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DELAY_W    = 16;
   localparam int FRAME_W    = 13;
   localparam int POS_W      = 12;
   localparam int MAX_FRAME  = 4096;

   localparam int GAIN_W    = 18;
   localparam int GAIN_FRAC = 17;
   localparam longint unsigned GAIN_ONE = 64'd131072;

   // pi in q30
   localparam longint unsigned PI_Q30 = 64'd3373259426;

   // taylor series denominators (2j)(2j+1) for j = 1..6
   localparam longint unsigned TAYLOR_DIV [6] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
                                                  64'd156};

   typedef enum logic [OPCODE_W-1:0] {
      OP_SAMPLE  = 2'd0,
      OP_ARM_IN  = 2'd1,
      OP_ARM_OUT = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UP_DELAY   = 2'd0,
      CSR_DOWN_DELAY = 2'd1,
      CSR_FRAME_LEN  = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      RP_WAIT  = 2'd0,
      RP_DELAY = 2'd1,
      RP_RAMP  = 2'd2,
      RP_ON    = 2'd3
   } rise_phase_type;

   typedef enum logic [2:0] {
      FP_BEGIN = 3'd0,
      FP_DELAY = 3'd1,
      FP_RAMP  = 3'd2,
      FP_ZERO  = 3'd3,
      FP_OFF   = 3'd4
   } fall_phase_type;

   typedef enum logic [1:0] {
      GM_PASS = 2'd0,
      GM_ZERO = 2'd1,
      GM_RAMP = 2'd2
   } gain_mode_type;

   // raised cosine gain in q1.17 from a q30 angle magnitude; upper selects 1+sin
   function automatic logic [GAIN_W-1:0] rc_gain_from_angle(input logic [63:0] angle,
                                                            input logic upper);
      logic [63:0] term;
      logic signed [63:0] sum;
      logic signed [63:0] val;
      logic [63:0] g;
      term = angle;
      sum  = $signed(angle);
      for (int j = 0; j < 6; j++) begin
         term = (term * angle) >> 30;
         term = (term * angle) >> 30;
         term = term / TAYLOR_DIV[j];
         if ((j & 1) == 0) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
      end
      if (sum < 0) begin
         sum = 64'sd0;
      end
      if (upper) begin
         val = (64'sd1 <<< 30) + sum;
      end else begin
         val = (64'sd1 <<< 30) - sum;
      end
      if (val < 0) begin
         val = 64'sd0;
      end
      if (val > (64'sd1 <<< 31)) begin
         val = 64'sd1 <<< 31;
      end
      g = ($unsigned(val) + 64'd8192) >> 14;
      if (g > GAIN_ONE) begin
         g = GAIN_ONE;
      end
      return g[GAIN_W-1:0];
   endfunction

endpackage

// ----- rtl/rcmr_channels.sv -----
// request, response and register write channel interfaces
`timescale 1ns / 1ps

interface rcmr_req_if import rcmr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic [OPCODE_W-1:0]           opcode;
   logic signed [SAMPLE_BITS-1:0] sample_i;
   logic signed [SAMPLE_BITS-1:0] sample_q;

   modport source (output valid, output opcode, output sample_i, output sample_q,
                   input ready);
   modport sink (input valid, input opcode, input sample_i, input sample_q,
                 output ready);
endinterface

interface rcmr_rsp_if import rcmr_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) ();
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] out_i;
   logic signed [SAMPLE_BITS-1:0] out_q;
   logic                          fade_in_done;
   logic                          fade_out_done;

   modport source (output valid, output out_i, output out_q, output fade_in_done,
                   output fade_out_done, input ready);
   modport sink (input valid, input out_i, input out_q, input fade_in_done,
                 input fade_out_done, output ready);
endinterface

interface rcmr_csr_if import rcmr_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/rcmr_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps

module rcmr_ram #(
   parameter int WIDTH = 18,
   parameter int DEPTH = 513,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- rtl/raised_cosine_mute_ramp.sv -----
// raised cosine fade-in / fade-out gain stages on an i/q sample stream
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Raised cosine mute ramp. Every request carries an opcode: a sample request
// (opcode 0) yields exactly one response with the i/q pair after the fade-in
// stage and then the fade-out stage; an arm fade-in (1) or arm fade-out (2)
// request, or the unused opcode 3, yields no response. Arms take effect at the
// next frame start. Throughput is one request per clock while the response side
// does not stall; a sample passes state update and gain table read, fade-in
// multiply, then fade-out multiply into the output register, and is held back
// only while the response side stalls. The per-sample phase and count update
// is combinational, registered as the sample is taken, which is what lets
// requests follow back to back. The two gain tables live in block rams that
// are loaded after reset: the load writes entries 0 to max(RISE_RAMP_LEN,
// FALL_RAMP_LEN), during which req_ch.ready stays low; register writes are
// taken at any time (csr_ch.ready is always high) but should only be made
// while the block is idle. Gains are unsigned q1.17 and products are floored.
module raised_cosine_mute_ramp import rcmr_pkg::*; #(
   parameter int RISE_RAMP_LEN = RISE_RAMP_LEN_DEF,
   parameter int FALL_RAMP_LEN = FALL_RAMP_LEN_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   rcmr_req_if.sink    req_ch,
   rcmr_rsp_if.source  rsp_ch,
   rcmr_csr_if.sink    csr_ch
);

   // ---------------------------------------------------------------------
   // derived sizes
   // ---------------------------------------------------------------------
   localparam int RA_W     = $clog2(RISE_RAMP_LEN + 1);
   localparam int FA_W     = $clog2(FALL_RAMP_LEN + 1);
   localparam int FILL_MAX = (RISE_RAMP_LEN > FALL_RAMP_LEN) ? RISE_RAMP_LEN : FALL_RAMP_LEN;
   localparam int FILL_W   = $clog2(FILL_MAX + 1);
   localparam int RCW      = (DELAY_W > RA_W) ? DELAY_W : RA_W;
   localparam int FCW      = (DELAY_W > FA_W) ? DELAY_W : FA_W;
   localparam int PROD_W   = SAMPLE_BITS + GAIN_W + 1;

   localparam logic [RCW-1:0]    RISE_LEN_C    = RCW'(RISE_RAMP_LEN);
   localparam logic [FCW-1:0]    FALL_LEN_C    = FCW'(FALL_RAMP_LEN);
   localparam logic [FCW-1:0]    FALL_ZERO_MAX = FCW'(MAX_FRAME);
   localparam logic [FILL_W-1:0] FILL_LAST     = FILL_W'(FILL_MAX);
   localparam logic [FILL_W-1:0] RISE_FILL_END = FILL_W'(RISE_RAMP_LEN);
   localparam logic [FILL_W-1:0] FALL_FILL_END = FILL_W'(FALL_RAMP_LEN);
   localparam logic [FRAME_W-1:0] FRAME_MAX_C  = FRAME_W'(MAX_FRAME);

   // ---------------------------------------------------------------------
   // gain tables, evaluated at elaboration and loaded into the rams
   // ---------------------------------------------------------------------
   logic [GAIN_W-1:0] rise_tab [RISE_RAMP_LEN + 1];
   logic [GAIN_W-1:0] fall_tab [FALL_RAMP_LEN + 1];

   for (genvar k = 0; k <= RISE_RAMP_LEN; k++) begin : g_rise_tab
      localparam longint unsigned DIST = (2 * k >= RISE_RAMP_LEN) ?
                                         longint'(2 * k - RISE_RAMP_LEN) :
                                         longint'(RISE_RAMP_LEN - 2 * k);
      localparam longint unsigned ANGLE = DIST * PI_Q30 / (2 * RISE_RAMP_LEN);
      localparam logic [GAIN_W-1:0] GAIN =
         rc_gain_from_angle(ANGLE, (2 * k >= RISE_RAMP_LEN));
      assign rise_tab[k] = GAIN;
   end

   // fall entry k is the rise-shaped curve taken at FALL_RAMP_LEN - k
   for (genvar k = 0; k <= FALL_RAMP_LEN; k++) begin : g_fall_tab
      localparam longint unsigned DIST = (2 * (FALL_RAMP_LEN - k) >= FALL_RAMP_LEN) ?
                                         longint'(FALL_RAMP_LEN - 2 * k) :
                                         longint'(2 * k - FALL_RAMP_LEN);
      localparam longint unsigned ANGLE = DIST * PI_Q30 / (2 * FALL_RAMP_LEN);
      localparam logic [GAIN_W-1:0] GAIN =
         rc_gain_from_angle(ANGLE, (2 * (FALL_RAMP_LEN - k) >= FALL_RAMP_LEN));
      assign fall_tab[k] = GAIN;
   end

   // ---------------------------------------------------------------------
   // signals
   // ---------------------------------------------------------------------
   logic                  filling_ff;
   logic [FILL_W-1:0]     fill_idx_ff;

   logic [DELAY_W-1:0]    up_delay_ff;
   logic [DELAY_W-1:0]    down_delay_ff;
   logic [FRAME_W-1:0]    frame_len_ff;

   rise_phase_type        rise_phase_ff, rise_phase_in;
   logic [RCW-1:0]        rise_count_ff, rise_count_in;
   fall_phase_type        fall_phase_ff, fall_phase_in;
   logic [FCW-1:0]        fall_count_ff, fall_count_in;
   logic                  rise_armed_ff, rise_armed_in;
   logic                  fall_armed_ff, fall_armed_in;
   logic                  rise_frame_ff;
   logic                  fall_frame_ff;
   logic [POS_W-1:0]      frame_pos_ff;

   logic                  req_acc;
   logic                  sample_acc;
   logic                  arm_in_acc;
   logic                  arm_out_acc;
   logic                  nonzero;
   logic [FRAME_W-1:0]    flen;
   logic                  frame_start;
   logic                  frame_last;
   logic                  rise_active;
   logic                  fall_active;

   gain_mode_type         rise_mode;
   gain_mode_type         fall_mode;
   logic                  rise_done;
   logic                  fall_done;
   logic [RCW-1:0]        rise_idx;
   logic [FCW-1:0]        fall_idx;

   logic [GAIN_W-1:0]     rise_rd_data;
   logic [GAIN_W-1:0]     fall_rd_data;

   // pipeline enables, back to front
   logic                  out_en;
   logic                  s2_en;
   logic                  s1_en;

   logic                          s1_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s1_i_ff;
   logic signed [SAMPLE_BITS-1:0] s1_q_ff;
   gain_mode_type                 s1_rise_mode_ff;
   gain_mode_type                 s1_fall_mode_ff;
   logic                          s1_in_done_ff;
   logic                          s1_out_done_ff;

   logic                          s2_valid_ff;
   logic signed [SAMPLE_BITS-1:0] s2_i_ff;
   logic signed [SAMPLE_BITS-1:0] s2_q_ff;
   logic [GAIN_W-1:0]             s2_fall_gain_ff;
   gain_mode_type                 s2_fall_mode_ff;
   logic                          s2_in_done_ff;
   logic                          s2_out_done_ff;

   logic                          out_valid_ff;
   logic signed [SAMPLE_BITS-1:0] out_i_ff;
   logic signed [SAMPLE_BITS-1:0] out_q_ff;
   logic                          out_in_done_ff;
   logic                          out_out_done_ff;

   logic signed [PROD_W-1:0]      rise_prod_i;
   logic signed [PROD_W-1:0]      rise_prod_q;
   logic signed [PROD_W-1:0]      fall_prod_i;
   logic signed [PROD_W-1:0]      fall_prod_q;
   logic signed [SAMPLE_BITS-1:0] s2_i_in;
   logic signed [SAMPLE_BITS-1:0] s2_q_in;
   logic signed [SAMPLE_BITS-1:0] out_i_in;
   logic signed [SAMPLE_BITS-1:0] out_q_in;

   // ---------------------------------------------------------------------
   // gain table load after reset
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         filling_ff  <= 1'b1;
         fill_idx_ff <= '0;
      end else if (filling_ff) begin
         if (fill_idx_ff == FILL_LAST) begin
            filling_ff <= 1'b0;
         end else begin
            fill_idx_ff <= fill_idx_ff + FILL_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // register writes
   // ---------------------------------------------------------------------
   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         up_delay_ff   <= '0;
         down_delay_ff <= '0;
         frame_len_ff  <= FRAME_W'(1024);
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_UP_DELAY:   up_delay_ff   <= csr_ch.data[DELAY_W-1:0];
            CSR_DOWN_DELAY: down_delay_ff <= csr_ch.data[DELAY_W-1:0];
            CSR_FRAME_LEN:  frame_len_ff  <= csr_ch.data[FRAME_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // request decode and frame tracking
   // ---------------------------------------------------------------------
   assign req_ch.ready = s1_en && !filling_ff;
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign sample_acc   = req_acc && (req_ch.opcode == OP_SAMPLE);
   assign arm_in_acc   = req_acc && (req_ch.opcode == OP_ARM_IN);
   assign arm_out_acc  = req_acc && (req_ch.opcode == OP_ARM_OUT);
   assign nonzero      = (req_ch.sample_i != '0) || (req_ch.sample_q != '0);

   // zero frame length acts as one, oversize lengths clamp to the max frame
   always_comb begin
      if (frame_len_ff == '0) begin
         flen = FRAME_W'(1);
      end else if (frame_len_ff > FRAME_MAX_C) begin
         flen = FRAME_MAX_C;
      end else begin
         flen = frame_len_ff;
      end
   end

   assign frame_start = (frame_pos_ff == '0);
   assign frame_last  = ((FRAME_W'(frame_pos_ff) + FRAME_W'(1)) >= flen);
   // at frame start the stages take their arm flags
   assign rise_active = frame_start ? rise_armed_ff : rise_frame_ff;
   assign fall_active = frame_start ? fall_armed_ff : fall_frame_ff;

   // ---------------------------------------------------------------------
   // fade-in stage: next state
   // ---------------------------------------------------------------------
   always_comb begin
      rise_phase_in = rise_phase_ff;
      rise_count_in = rise_count_ff;
      if (rise_active) begin
         unique case (rise_phase_ff)
            RP_WAIT: begin
               // signal appears: start the hold-off, or go straight to the ramp
               if (nonzero) begin
                  if (up_delay_ff != '0) begin
                     rise_phase_in = RP_DELAY;
                     rise_count_in = RCW'(up_delay_ff);
                  end else begin
                     rise_phase_in = RP_RAMP;
                     rise_count_in = RISE_LEN_C;
                  end
               end
            end
            RP_DELAY: begin
               if (rise_count_ff == '0) begin
                  rise_phase_in = RP_RAMP;
                  rise_count_in = RISE_LEN_C;
               end else begin
                  rise_count_in = rise_count_ff - RCW'(1);
               end
            end
            RP_RAMP: begin
               if (rise_count_ff == '0) begin
                  rise_phase_in = RP_ON;
               end else begin
                  rise_count_in = rise_count_ff - RCW'(1);
               end
            end
            RP_ON: begin
               if (frame_last) begin
                  rise_phase_in = RP_WAIT;
               end
            end
         endcase
      end
   end

   // fade-in stage: outputs
   always_comb begin
      rise_mode = GM_PASS;
      rise_done = 1'b0;
      rise_idx  = RISE_LEN_C - rise_count_ff;
      if (rise_active) begin
         unique case (rise_phase_ff)
            RP_WAIT:  rise_mode = GM_ZERO;
            RP_DELAY: rise_mode = GM_ZERO;
            RP_RAMP:  rise_mode = GM_RAMP;
            RP_ON:    rise_done = frame_last;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // fade-out stage: next state
   // ---------------------------------------------------------------------
   always_comb begin
      fall_phase_in = fall_phase_ff;
      fall_count_in = fall_count_ff;
      if (fall_active) begin
         unique case (fall_phase_ff)
            FP_BEGIN: begin
               if (down_delay_ff != '0) begin
                  fall_phase_in = FP_DELAY;
                  fall_count_in = FCW'(down_delay_ff);
               end else begin
                  fall_phase_in = FP_RAMP;
                  fall_count_in = FALL_LEN_C;
               end
            end
            FP_DELAY: begin
               if (fall_count_ff == '0) begin
                  fall_phase_in = FP_RAMP;
                  fall_count_in = FALL_LEN_C;
               end else begin
                  fall_count_in = fall_count_ff - FCW'(1);
               end
            end
            FP_RAMP: begin
               // zero tail runs frame length plus one samples
               if (fall_count_ff == '0) begin
                  fall_phase_in = FP_ZERO;
                  fall_count_in = FCW'(flen);
               end else begin
                  fall_count_in = fall_count_ff - FCW'(1);
               end
            end
            FP_ZERO: begin
               if (fall_count_ff == '0) begin
                  fall_phase_in = FP_OFF;
               end else begin
                  fall_count_in = fall_count_ff - FCW'(1);
               end
            end
            FP_OFF: begin
               if (frame_last) begin
                  fall_phase_in = FP_BEGIN;
               end
            end
            default: fall_phase_in = FP_BEGIN;
         endcase
      end
   end

   // fade-out stage: outputs
   always_comb begin
      fall_mode = GM_PASS;
      fall_done = 1'b0;
      fall_idx  = FALL_LEN_C - fall_count_ff;
      if (fall_active) begin
         unique case (fall_phase_ff)
            FP_BEGIN: fall_mode = GM_PASS;
            FP_DELAY: fall_mode = GM_PASS;
            FP_RAMP:  fall_mode = GM_RAMP;
            FP_ZERO:  fall_mode = GM_ZERO;
            FP_OFF: begin
               fall_mode = GM_ZERO;
               fall_done = frame_last;
            end
            default:  fall_mode = GM_PASS;
         endcase
      end
   end

   // arm flags: set by an arm request, cleared when the stage completes
   always_comb begin
      rise_armed_in = rise_armed_ff;
      fall_armed_in = fall_armed_ff;
      if (arm_in_acc) begin
         rise_armed_in = 1'b1;
      end else if (sample_acc && rise_done) begin
         rise_armed_in = 1'b0;
      end
      if (arm_out_acc) begin
         fall_armed_in = 1'b1;
      end else if (sample_acc && fall_done) begin
         fall_armed_in = 1'b0;
      end
   end

   // ---------------------------------------------------------------------
   // control state registers
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rise_phase_ff <= RP_WAIT;
         rise_count_ff <= '0;
         fall_phase_ff <= FP_BEGIN;
         fall_count_ff <= '0;
         rise_armed_ff <= 1'b0;
         fall_armed_ff <= 1'b0;
         rise_frame_ff <= 1'b0;
         fall_frame_ff <= 1'b0;
         frame_pos_ff  <= '0;
      end else begin
         rise_armed_ff <= rise_armed_in;
         fall_armed_ff <= fall_armed_in;
         if (sample_acc) begin
            rise_phase_ff <= rise_phase_in;
            rise_count_ff <= rise_count_in;
            fall_phase_ff <= fall_phase_in;
            fall_count_ff <= fall_count_in;
            if (frame_start) begin
               rise_frame_ff <= rise_armed_ff;
               fall_frame_ff <= fall_armed_ff;
            end
            frame_pos_ff <= frame_last ? '0 : frame_pos_ff + POS_W'(1);
         end
      end
   end

   // ---------------------------------------------------------------------
   // gain table rams: loaded once, then read with the sample's ramp index
   // ---------------------------------------------------------------------
   rcmr_ram #(
      .WIDTH (GAIN_W),
      .DEPTH (RISE_RAMP_LEN + 1)
   ) u_rise_ram (
      .clock   (clock),
      .wr_en   (filling_ff && (fill_idx_ff <= RISE_FILL_END)),
      .wr_addr (fill_idx_ff[RA_W-1:0]),
      .wr_data (rise_tab[fill_idx_ff[RA_W-1:0]]),
      .rd_en   (sample_acc),
      .rd_addr (rise_idx[RA_W-1:0]),
      .rd_data (rise_rd_data)
   );

   rcmr_ram #(
      .WIDTH (GAIN_W),
      .DEPTH (FALL_RAMP_LEN + 1)
   ) u_fall_ram (
      .clock   (clock),
      .wr_en   (filling_ff && (fill_idx_ff <= FALL_FILL_END)),
      .wr_addr (fill_idx_ff[FA_W-1:0]),
      .wr_data (fall_tab[fill_idx_ff[FA_W-1:0]]),
      .rd_en   (sample_acc),
      .rd_addr (fall_idx[FA_W-1:0]),
      .rd_data (fall_rd_data)
   );

   // ---------------------------------------------------------------------
   // sample pipeline: s1 (table read) -> s2 (fade-in) -> output (fade-out)
   // ---------------------------------------------------------------------
   assign out_en = !out_valid_ff || rsp_ch.ready;
   assign s2_en  = !s2_valid_ff || out_en;
   assign s1_en  = !s1_valid_ff || s2_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_en) begin
         s1_valid_ff <= sample_acc;
      end
   end

   always_ff @(posedge clock) begin
      if (sample_acc) begin
         s1_i_ff         <= req_ch.sample_i;
         s1_q_ff         <= req_ch.sample_q;
         s1_rise_mode_ff <= rise_mode;
         s1_fall_mode_ff <= fall_mode;
         s1_in_done_ff   <= rise_done;
         s1_out_done_ff  <= fall_done;
      end
   end

   // fade-in gain, floored q1.17 product
   assign rise_prod_i = $signed(s1_i_ff) * $signed({1'b0, rise_rd_data});
   assign rise_prod_q = $signed(s1_q_ff) * $signed({1'b0, rise_rd_data});

   always_comb begin
      unique case (s1_rise_mode_ff)
         GM_ZERO: begin
            s2_i_in = '0;
            s2_q_in = '0;
         end
         GM_RAMP: begin
            s2_i_in = rise_prod_i[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
            s2_q_in = rise_prod_q[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
         end
         default: begin
            s2_i_in = s1_i_ff;
            s2_q_in = s1_q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_en) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_en && s1_valid_ff) begin
         s2_i_ff         <= s2_i_in;
         s2_q_ff         <= s2_q_in;
         s2_fall_gain_ff <= fall_rd_data;
         s2_fall_mode_ff <= s1_fall_mode_ff;
         s2_in_done_ff   <= s1_in_done_ff;
         s2_out_done_ff  <= s1_out_done_ff;
      end
   end

   // fade-out gain on the fade-in result
   assign fall_prod_i = $signed(s2_i_ff) * $signed({1'b0, s2_fall_gain_ff});
   assign fall_prod_q = $signed(s2_q_ff) * $signed({1'b0, s2_fall_gain_ff});

   always_comb begin
      unique case (s2_fall_mode_ff)
         GM_ZERO: begin
            out_i_in = '0;
            out_q_in = '0;
         end
         GM_RAMP: begin
            out_i_in = fall_prod_i[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
            out_q_in = fall_prod_q[SAMPLE_BITS+GAIN_FRAC-1:GAIN_FRAC];
         end
         default: begin
            out_i_in = s2_i_ff;
            out_q_in = s2_q_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_en) begin
         out_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en && s2_valid_ff) begin
         out_i_ff        <= out_i_in;
         out_q_ff        <= out_q_in;
         out_in_done_ff  <= s2_in_done_ff;
         out_out_done_ff <= s2_out_done_ff;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.out_i         = out_i_ff;
   assign rsp_ch.out_q         = out_q_ff;
   assign rsp_ch.fade_in_done  = out_in_done_ff;
   assign rsp_ch.fade_out_done = out_out_done_ff;

   // ---------------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------------
   `RCMR_ASSERT_IMPL(a_rise_ramp_index, rise_phase_ff == RP_RAMP, rise_count_ff <= RISE_LEN_C, "rise ramp count past table end")
   `RCMR_ASSERT_IMPL(a_fall_zero_count, fall_phase_ff == FP_ZERO, fall_count_ff <= FALL_ZERO_MAX, "fall zero tail count past max frame")
   `RCMR_ASSERT_NEXT(a_frame_wrap, sample_acc && frame_last, frame_pos_ff == '0, "frame position did not wrap on last sample")
   `RCMR_ASSERT_NEXT(a_fill_end, filling_ff && (fill_idx_ff == FILL_LAST), !filling_ff, "table load did not finish on last entry")
   `RCMR_ASSERT_NEXT(a_rise_complete, sample_acc && rise_done, (rise_phase_ff == RP_WAIT) && !rise_armed_ff, "fade-in completion did not disarm")

endmodule
